FILE: sv/cmfu_pkg.sv
package cmfu_pkg;

	// Default width of one direction component
	localparam int CMFU_COMPONENT_WIDTH = 16;

	// Width of the half-tile registers; also bounds every quotient
	localparam int HALF_TILE_BITS = 14;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = HALF_TILE_BITS;
	localparam int TEX_W = 16;
	localparam int FACE_W = 3;

	// Face centers, Q0.16
	localparam logic [TEX_W-1:0] C_1_8 = 16'd8192;
	localparam logic [TEX_W-1:0] C_3_8 = 16'd24576;
	localparam logic [TEX_W-1:0] C_5_8 = 16'd40960;
	localparam logic [TEX_W-1:0] C_7_8 = 16'd57344;
	localparam logic [TEX_W-1:0] C_1_2 = 16'd32768;
	localparam logic [TEX_W-1:0] C_1_6 = 16'd10923;
	localparam logic [TEX_W-1:0] C_5_6 = 16'd54613;

	typedef enum logic [FACE_W-1:0] {
		FACE_FRONT  = 3'd0,
		FACE_BACK   = 3'd1,
		FACE_RIGHT  = 3'd2,
		FACE_LEFT   = 3'd3,
		FACE_TOP    = 3'd4,
		FACE_BOTTOM = 3'd5
	} face_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_HALF_TILE_WIDTH  = 1'b0,
		REG_HALF_TILE_HEIGHT = 1'b1
	} cfg_index_t;

	// Per-request control that travels beside the data
	typedef struct packed {
		face_t face;
		logic  neg_u;
		logic  neg_v;
		logic  zero_major;
	} cmfu_ctl_t;

	function automatic logic [TEX_W-1:0] center_u(input face_t f);
		logic [TEX_W-1:0] c;
		case (f)
			FACE_BACK:  c = C_7_8;
			FACE_RIGHT: c = C_5_8;
			FACE_LEFT:  c = C_1_8;
			default:    c = C_3_8;
		endcase
		return c;
	endfunction

	function automatic logic [TEX_W-1:0] center_v(input face_t f);
		logic [TEX_W-1:0] c;
		case (f)
			FACE_TOP:    c = C_5_6;
			FACE_BOTTOM: c = C_1_6;
			default:     c = C_1_2;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/cmfu_ray_if.sv
interface cmfu_ray_if
	import cmfu_pkg::*;
#(
	parameter int COMPONENT_WIDTH = CMFU_COMPONENT_WIDTH
);
	logic                              valid;
	logic                              ready;
	logic signed [COMPONENT_WIDTH-1:0] ray_x;
	logic signed [COMPONENT_WIDTH-1:0] ray_y;
	logic signed [COMPONENT_WIDTH-1:0] ray_z;

	modport source (output valid, ray_x, ray_y, ray_z, input ready);
	modport sink (input valid, ray_x, ray_y, ray_z, output ready);
endinterface

FILE: sv/cmfu_tex_if.sv
interface cmfu_tex_if
	import cmfu_pkg::*;
;
	logic             valid;
	logic             ready;
	logic [FACE_W-1:0] face;
	logic [TEX_W-1:0]  tex_u;
	logic [TEX_W-1:0]  tex_v;

	modport source (output valid, face, tex_u, tex_v, input ready);
	modport sink (input valid, face, tex_u, tex_v, output ready);
endinterface

FILE: sv/cmfu_front.sv
module cmfu_front
	import cmfu_pkg::*;
#(
	parameter int COMPONENT_WIDTH = CMFU_COMPONENT_WIDTH,
	localparam int CW = COMPONENT_WIDTH,
	localparam int DW = COMPONENT_WIDTH + HALF_TILE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [CW-1:0]      ray_x,
	input  logic signed [CW-1:0]      ray_y,
	input  logic signed [CW-1:0]      ray_z,
	input  logic [HALF_TILE_BITS-1:0] half_w,
	input  logic [HALF_TILE_BITS-1:0] half_h,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [DW-1:0]             prod_u,
	output logic [DW-1:0]             prod_v,
	output logic [CW-1:0]             major,
	output cmfu_ctl_t                 ctl
);

	logic [CW-1:0] ax, ay, az;
	logic          sx, sy, sz;
	logic          pos_x, pos_y, pos_z;
	logic          z_major, x_major;
	logic [CW-1:0] mag_u_c, mag_v_c, major_c;
	cmfu_ctl_t     ctl_c;

	logic          v_s1;
	logic [CW-1:0] mag_u_s1, mag_v_s1, major_s1;
	cmfu_ctl_t     ctl_s1;
	logic          rdy_s1;

	logic          v_s2;
	logic [DW-1:0] prod_u_s2, prod_v_s2;
	logic [CW-1:0] major_s2;
	cmfu_ctl_t     ctl_s2;
	logic          rdy_s2;

	// Take magnitudes and signs of the three components
	always_comb begin
		sx = ray_x[CW-1];
		sy = ray_y[CW-1];
		sz = ray_z[CW-1];
		ax = sx ? (~ray_x + 1'b1) : ray_x;
		ay = sy ? (~ray_y + 1'b1) : ray_y;
		az = sz ? (~ray_z + 1'b1) : ray_z;
		pos_x = !sx && (ray_x != '0);
		pos_y = !sy && (ray_y != '0);
		pos_z = !sz && (ray_z != '0);
		z_major = (az >= ax) && (az >= ay);
		x_major = (ax >= ay);
	end

	// Pick the face and route the two minor components to u and v
	always_comb begin
		ctl_c = '0;
		if (z_major) begin
			ctl_c.face  = pos_z ? FACE_FRONT : FACE_BACK;
			mag_u_c     = ax;
			mag_v_c     = ay;
			major_c     = az;
			ctl_c.neg_u = sx ^ !pos_z;
			ctl_c.neg_v = sy;
		end else if (x_major) begin
			ctl_c.face  = pos_x ? FACE_RIGHT : FACE_LEFT;
			mag_u_c     = az;
			mag_v_c     = ay;
			major_c     = ax;
			ctl_c.neg_u = sz ^ pos_x;
			ctl_c.neg_v = sy;
		end else begin
			ctl_c.face  = pos_y ? FACE_TOP : FACE_BOTTOM;
			mag_u_c     = ax;
			mag_v_c     = az;
			major_c     = ay;
			ctl_c.neg_u = sx;
			ctl_c.neg_v = sz ^ pos_y;
		end
		ctl_c.zero_major = (major_c == '0);
	end

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Stage 1: hold the selected request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mag_u_s1 <= mag_u_c;
			mag_v_s1 <= mag_v_c;
			major_s1 <= major_c;
			ctl_s1   <= ctl_c;
		end
	end

	// Stage 2: scale the minor magnitudes by the half-tile sizes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			prod_u_s2 <= DW'(mag_u_s1) * DW'(half_w);
			prod_v_s2 <= DW'(mag_v_s1) * DW'(half_h);
			major_s2  <= major_s1;
			ctl_s2    <= ctl_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod_u    = prod_u_s2;
	assign prod_v    = prod_v_s2;
	assign major     = major_s2;
	assign ctl       = ctl_s2;

`ifndef NO_ASSERTIONS
	a_zero_major_minor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && ctl_s1.zero_major |-> (mag_u_s1 == '0) && (mag_v_s1 == '0))
		else $error("minor component exceeds a zero major component");
`endif

endmodule

FILE: sv/cmfu_div.sv
module cmfu_div
	import cmfu_pkg::*;
#(
	parameter int COMPONENT_WIDTH = CMFU_COMPONENT_WIDTH,
	localparam int CW = COMPONENT_WIDTH,
	localparam int QW = HALF_TILE_BITS,
	localparam int DW = COMPONENT_WIDTH + HALF_TILE_BITS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [DW-1:0] dividend_u,
	input  logic [DW-1:0] dividend_v,
	input  logic [CW-1:0] divisor,
	input  cmfu_ctl_t     in_ctl,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [QW-1:0] quot_u,
	output logic [QW-1:0] quot_v,
	output cmfu_ctl_t     out_ctl
);

	// One quotient bit per stage, most significant first; both lanes share the divisor
	logic          v_s      [QW];
	logic [DW-1:0] rem_u_s  [QW];
	logic [DW-1:0] rem_v_s  [QW];
	logic [QW-1:0] q_u_s    [QW];
	logic [QW-1:0] q_v_s    [QW];
	logic [CW-1:0] dvs_s    [QW];
	cmfu_ctl_t     ctl_s    [QW];
	logic          rdy_s    [QW];

	genvar k;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			localparam int B = QW - 1 - k;

			logic          vin;
			logic [DW-1:0] rin_u, rin_v;
			logic [QW-1:0] qin_u, qin_v;
			logic [CW-1:0] dvs_in;
			cmfu_ctl_t     ctl_in;
			logic          rdy_next;
			logic [DW-1:0] shifted;
			logic [DW:0]   diff_u, diff_v;

			if (k == 0) begin : g_first
				assign vin    = in_valid;
				assign rin_u  = dividend_u;
				assign rin_v  = dividend_v;
				assign qin_u  = '0;
				assign qin_v  = '0;
				assign dvs_in = divisor;
				assign ctl_in = in_ctl;
			end else begin : g_rest
				assign vin    = v_s[k-1];
				assign rin_u  = rem_u_s[k-1];
				assign rin_v  = rem_v_s[k-1];
				assign qin_u  = q_u_s[k-1];
				assign qin_v  = q_v_s[k-1];
				assign dvs_in = dvs_s[k-1];
				assign ctl_in = ctl_s[k-1];
			end

			if (k == QW - 1) begin : g_last
				assign rdy_next = out_ready;
			end else begin : g_mid
				assign rdy_next = rdy_s[k+1];
			end

			assign rdy_s[k] = !v_s[k] || rdy_next;

			// Trial subtract of the divisor shifted to this bit
			assign shifted = DW'(dvs_in) << B;
			assign diff_u  = {1'b0, rin_u} - {1'b0, shifted};
			assign diff_v  = {1'b0, rin_v} - {1'b0, shifted};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (rdy_s[k]) begin
					v_s[k] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy_s[k] && vin) begin
					rem_u_s[k] <= diff_u[DW] ? rin_u : diff_u[DW-1:0];
					rem_v_s[k] <= diff_v[DW] ? rin_v : diff_v[DW-1:0];
					q_u_s[k]   <= qin_u | (QW'(!diff_u[DW]) << B);
					q_v_s[k]   <= qin_v | (QW'(!diff_v[DW]) << B);
					dvs_s[k]   <= dvs_in;
					ctl_s[k]   <= ctl_in;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy_s[0];
	assign out_valid = v_s[QW-1];
	// A zero divisor only comes with zero dividends; the offset is zero then
	assign quot_u    = ctl_s[QW-1].zero_major ? '0 : q_u_s[QW-1];
	assign quot_v    = ctl_s[QW-1].zero_major ? '0 : q_v_s[QW-1];
	assign out_ctl   = ctl_s[QW-1];

`ifndef NO_ASSERTIONS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QW-1] && !ctl_s[QW-1].zero_major |->
			(rem_u_s[QW-1] < DW'(dvs_s[QW-1])) && (rem_v_s[QW-1] < DW'(dvs_s[QW-1])))
		else $error("divider remainder not below divisor");

	a_zero_divisor_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s[QW-1] && ctl_s[QW-1].zero_major |->
			(rem_u_s[QW-1] == '0) && (rem_v_s[QW-1] == '0))
		else $error("nonzero remainder with zero divisor");
`endif

endmodule

FILE: sv/cmfu_finish.sv
module cmfu_finish
	import cmfu_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [HALF_TILE_BITS-1:0] quot_u,
	input  logic [HALF_TILE_BITS-1:0] quot_v,
	input  cmfu_ctl_t                 in_ctl,
	cmfu_tex_if.source                tex
);

	localparam int SW = TEX_W + 2;

	logic signed [SW-1:0] off_u, off_v;
	logic signed [SW-1:0] sum_u, sum_v;
	logic [TEX_W-1:0]     sat_u, sat_v;

	logic             valid_q;
	logic [FACE_W-1:0] face_q;
	logic [TEX_W-1:0]  tex_u_q, tex_v_q;

	// Add the signed offsets to the face center and clamp to 0..65535
	always_comb begin
		off_u = $signed(SW'(quot_u));
		off_v = $signed(SW'(quot_v));
		if (in_ctl.neg_u) begin
			off_u = -off_u;
		end
		if (in_ctl.neg_v) begin
			off_v = -off_v;
		end
		sum_u = $signed(SW'(center_u(in_ctl.face))) + off_u;
		sum_v = $signed(SW'(center_v(in_ctl.face))) + off_v;
		if (sum_u < 0) begin
			sat_u = '0;
		end else if (sum_u[SW-1:TEX_W] != '0) begin
			sat_u = '1;
		end else begin
			sat_u = sum_u[TEX_W-1:0];
		end
		if (sum_v < 0) begin
			sat_v = '0;
		end else if (sum_v[SW-1:TEX_W] != '0) begin
			sat_v = '1;
		end else begin
			sat_v = sum_v[TEX_W-1:0];
		end
	end

	assign in_ready = !valid_q || tex.ready;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			face_q  <= in_ctl.face;
			tex_u_q <= sat_u;
			tex_v_q <= sat_v;
		end
	end

	assign tex.valid = valid_q;
	assign tex.face  = face_q;
	assign tex.tex_u = tex_u_q;
	assign tex.tex_v = tex_v_q;

endmodule

FILE: sv/cube_map_face_uv.sv
// Pipeline: select, scale, 14 divider stages at one quotient bit each,
// then the output register.
// Throughput: one request per cycle; each stage moves on when the next has room.
// Reset: arst_n clears all valid bits and both half-tile registers to zero;
// data registers are not reset.
module cube_map_face_uv
	import cmfu_pkg::*;
#(
	parameter int COMPONENT_WIDTH = CMFU_COMPONENT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	cmfu_ray_if.sink               ray,
	cmfu_tex_if.source             tex,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW = COMPONENT_WIDTH;
	localparam int DW = COMPONENT_WIDTH + HALF_TILE_BITS;

	logic [HALF_TILE_BITS-1:0] half_w_q, half_h_q;

	logic                      fr_valid, fr_ready;
	logic [DW-1:0]             fr_prod_u, fr_prod_v;
	logic [CW-1:0]             fr_major;
	cmfu_ctl_t                 fr_ctl;

	logic                      dv_valid, dv_ready;
	logic [HALF_TILE_BITS-1:0] dv_quot_u, dv_quot_v;
	cmfu_ctl_t                 dv_ctl;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q <= '0;
			half_h_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				REG_HALF_TILE_WIDTH:  half_w_q <= cfg_data[HALF_TILE_BITS-1:0];
				REG_HALF_TILE_HEIGHT: half_h_q <= cfg_data[HALF_TILE_BITS-1:0];
				default: ;
			endcase
		end
	end

	cmfu_front #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ray.valid),
		.in_ready (ray.ready),
		.ray_x    (ray.ray_x),
		.ray_y    (ray.ray_y),
		.ray_z    (ray.ray_z),
		.half_w   (half_w_q),
		.half_h   (half_h_q),
		.out_valid(fr_valid),
		.out_ready(fr_ready),
		.prod_u   (fr_prod_u),
		.prod_v   (fr_prod_v),
		.major    (fr_major),
		.ctl      (fr_ctl)
	);

	cmfu_div #(
		.COMPONENT_WIDTH(COMPONENT_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.dividend_u(fr_prod_u),
		.dividend_v(fr_prod_v),
		.divisor   (fr_major),
		.in_ctl    (fr_ctl),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.quot_u    (dv_quot_u),
		.quot_v    (dv_quot_v),
		.out_ctl   (dv_ctl)
	);

	cmfu_finish u_finish (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(dv_valid),
		.in_ready(dv_ready),
		.quot_u  (dv_quot_u),
		.quot_v  (dv_quot_v),
		.in_ctl  (dv_ctl),
		.tex     (tex)
	);

`ifndef NO_ASSERTIONS
	a_empty_out_takes_request: assert property (@(posedge clk) disable iff (!arst_n)
		!tex.valid |-> ray.ready)
		else $error("request refused while output stage is empty");
`endif

endmodule
